/* hw/rtl/i2cmra_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and codes for the I2C register access master: sequence
// stages, the sequencer state record and the per-request pin result.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_START    = 5'd1,
        ST_CTRL     = 5'd2,
        ST_ACK_CTRL = 5'd3,
        ST_ADDR     = 5'd4,
        ST_ACK_ADDR = 5'd5,
        ST_DATA     = 5'd6,
        ST_ACK_DATA = 5'd7,
        ST_RESTART  = 5'd8,
        ST_CTRL_RD  = 5'd9,
        ST_ACK_RD   = 5'd10,
        ST_READ     = 5'd11,
        ST_NACK_OUT = 5'd12,
        ST_STOP     = 5'd13
    } stage_t;

    typedef struct packed {
        stage_t      stage;
        logic [1:0]  phase;
        logic [7:0]  timer;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic        is_read;
        logic [23:0] latched;
        logic [7:0]  read_result;
    } seq_state_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic       nack_error;
        logic [7:0] read_data;
    } seq_result_t;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] READ_BIT      = 8'h01;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [1:0] START_PHASES  = 2'd2;
    localparam logic [7:0] TICKS_RESET   = 8'd1;

endpackage

/* hw/rtl/i2cmra_seq.sv */
// ----------------------------------------------------------------------------
// I2C master sequencer step
// Works out the sequencer state after one request and the pin levels and
// status that the new state shows.
// ----------------------------------------------------------------------------
module i2cmra_seq (
    input  i2cmra_pkg::seq_state_t  state_cur,
    input  logic [1:0]              cmd,
    input  logic [7:0]              device_control,
    input  logic [7:0]              reg_address,
    input  logic [7:0]              write_data,
    input  logic                    sda_in,
    input  logic [7:0]              ticks_per_phase,
    output i2cmra_pkg::seq_state_t  state_nxt,
    output i2cmra_pkg::seq_result_t result
);
    import i2cmra_pkg::*;

    logic [7:0] timer_inc;
    logic [7:0] limit;
    logic [3:0] bit_inc;
    logic [7:0] ctrl_byte;
    logic       done;
    logic       nack;

    assign timer_inc = state_cur.timer + 8'd1;
    assign limit     = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
    assign bit_inc   = state_cur.bit_count + 4'd1;
    assign ctrl_byte = state_cur.latched[23:16];

    always_comb begin
        state_nxt = state_cur;
        done      = 1'b0;
        nack      = 1'b0;
        if (state_cur.stage == ST_IDLE) begin
            if (cmd == CMD_WRITE || cmd == CMD_READ) begin
                state_nxt.latched   = {device_control, reg_address, write_data};
                state_nxt.is_read   = (cmd == CMD_READ);
                state_nxt.stage     = ST_START;
                state_nxt.phase     = 2'd0;
                state_nxt.bit_count = 4'd0;
                state_nxt.timer     = 8'd0;
            end
        end else begin
            state_nxt.timer = timer_inc;
            if (timer_inc >= limit) begin
                state_nxt.timer = 8'd0;
                case (state_cur.stage)
                    ST_START, ST_RESTART: begin
                        if (state_cur.phase < START_PHASES) begin
                            state_nxt.phase = state_cur.phase + 2'd1;
                        end else begin
                            state_nxt.phase     = 2'd0;
                            state_nxt.bit_count = 4'd0;
                            if (state_cur.stage == ST_START) begin
                                state_nxt.stage      = ST_CTRL;
                                state_nxt.shift_byte = ctrl_byte;
                            end else begin
                                state_nxt.stage      = ST_CTRL_RD;
                                state_nxt.shift_byte = ctrl_byte | READ_BIT;
                            end
                        end
                    end
                    ST_CTRL, ST_ADDR, ST_DATA, ST_CTRL_RD, ST_READ: begin
                        if (state_cur.phase == 2'd0) begin
                            if (state_cur.stage == ST_READ) begin
                                state_nxt.shift_byte = {state_cur.shift_byte[6:0], sda_in};
                            end
                            state_nxt.phase = 2'd1;
                        end else begin
                            if (state_cur.stage != ST_READ) begin
                                state_nxt.shift_byte = {state_cur.shift_byte[6:0], 1'b0};
                            end
                            state_nxt.phase     = 2'd0;
                            state_nxt.bit_count = bit_inc;
                            if (bit_inc == BITS_PER_BYTE) begin
                                state_nxt.bit_count = 4'd0;
                                case (state_cur.stage)
                                    ST_CTRL:    state_nxt.stage = ST_ACK_CTRL;
                                    ST_ADDR:    state_nxt.stage = ST_ACK_ADDR;
                                    ST_DATA:    state_nxt.stage = ST_ACK_DATA;
                                    ST_CTRL_RD: state_nxt.stage = ST_ACK_RD;
                                    ST_READ: begin
                                        state_nxt.read_result = state_cur.shift_byte;
                                        state_nxt.stage       = ST_NACK_OUT;
                                    end
                                    default:    state_nxt.stage = ST_IDLE;
                                endcase
                            end
                        end
                    end
                    ST_ACK_CTRL, ST_ACK_ADDR, ST_ACK_DATA, ST_ACK_RD: begin
                        if (state_cur.phase == 2'd0) begin
                            if (sda_in) begin
                                done                = 1'b1;
                                nack                = 1'b1;
                                state_nxt.stage     = ST_IDLE;
                                state_nxt.phase     = 2'd0;
                                state_nxt.bit_count = 4'd0;
                            end else begin
                                state_nxt.phase = 2'd1;
                            end
                        end else begin
                            state_nxt.phase     = 2'd0;
                            state_nxt.bit_count = 4'd0;
                            case (state_cur.stage)
                                ST_ACK_CTRL: begin
                                    state_nxt.stage      = ST_ADDR;
                                    state_nxt.shift_byte = state_cur.latched[15:8];
                                end
                                ST_ACK_ADDR: begin
                                    if (state_cur.is_read) begin
                                        state_nxt.stage = ST_RESTART;
                                    end else begin
                                        state_nxt.stage      = ST_DATA;
                                        state_nxt.shift_byte = state_cur.latched[7:0];
                                    end
                                end
                                ST_ACK_DATA: state_nxt.stage = ST_STOP;
                                default: begin
                                    state_nxt.stage      = ST_READ;
                                    state_nxt.shift_byte = 8'd0;
                                end
                            endcase
                        end
                    end
                    ST_NACK_OUT: begin
                        if (state_cur.phase == 2'd0) begin
                            state_nxt.phase = 2'd1;
                        end else begin
                            state_nxt.stage     = ST_STOP;
                            state_nxt.phase     = 2'd0;
                            state_nxt.bit_count = 4'd0;
                        end
                    end
                    ST_STOP: begin
                        if (state_cur.phase == 2'd0) begin
                            state_nxt.phase = 2'd1;
                        end else begin
                            done                = 1'b1;
                            state_nxt.stage     = ST_IDLE;
                            state_nxt.phase     = 2'd0;
                            state_nxt.bit_count = 4'd0;
                        end
                    end
                    default: begin
                        done                = 1'b1;
                        state_nxt.stage     = ST_IDLE;
                        state_nxt.phase     = 2'd0;
                        state_nxt.bit_count = 4'd0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        result            = '0;
        result.sda_drive  = 1'b1;
        result.busy       = (state_nxt.stage != ST_IDLE);
        result.done       = done;
        result.nack_error = nack;
        result.read_data  = state_nxt.read_result;
        if (state_nxt.stage inside {ST_START, ST_RESTART}) begin
            result.scl     = (state_nxt.phase < START_PHASES);
            result.sda_out = (state_nxt.phase == 2'd0);
        end else if (state_nxt.stage inside {ST_CTRL, ST_ADDR, ST_DATA, ST_CTRL_RD}) begin
            result.scl     = (state_nxt.phase == 2'd0);
            result.sda_out = state_nxt.shift_byte[7];
        end else if (state_nxt.stage inside {ST_ACK_CTRL, ST_ACK_ADDR, ST_ACK_DATA,
                                             ST_ACK_RD}) begin
            result.scl       = (state_nxt.phase == 2'd0);
            result.sda_drive = (state_nxt.phase != 2'd0);
        end else if (state_nxt.stage == ST_READ) begin
            result.scl       = (state_nxt.phase == 2'd0);
            result.sda_drive = 1'b0;
        end else if (state_nxt.stage == ST_NACK_OUT) begin
            result.scl     = (state_nxt.phase == 2'd0);
            result.sda_out = (state_nxt.phase == 2'd0);
        end else if (state_nxt.stage == ST_STOP) begin
            result.scl     = 1'b1;
            result.sda_out = (state_nxt.phase != 2'd0);
        end
    end

endmodule

/* hw/rtl/i2c_master_register_access.sv */
// ----------------------------------------------------------------------------
// I2C master register access
// Runs a single byte write or a random read on SCL/SDA, one pin-level phase
// held for a programmable number of tick requests.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one tick; it carries a command (tick
// only, byte write or random read), the three transaction bytes and the
// sampled SDA level. Commands are taken only while no transaction runs.
// Every accepted request gives exactly one result on the m_ channel: the
// SCL/SDA levels to drive, busy, a one-request done pulse with its NACK flag
// and the byte of the last random read.
// The result is registered, so it appears in the cycle after its request
// is accepted. One request is taken every cycle while the receiver keeps
// taking results, because the whole sequencer step is a single pass of
// logic from the state register to the result register, and a new request
// is taken in the cycle that the waiting result is taken. When the receiver
// stalls, s_ready drops until the held result leaves. The cfg channel sets
// ticks_per_phase and is always ready. Reset returns the sequencer to idle,
// empties the result register and sets ticks_per_phase to one.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_device_control,
    input  logic [7:0] s_reg_address,
    input  logic [7:0] s_write_data,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl,
    output logic       m_sda_out,
    output logic       m_sda_drive,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic       m_nack_error,
    output logic [7:0] m_read_data
);
    import i2cmra_pkg::*;

    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t result_reg;
    seq_result_t result_next;
    logic [7:0]  ticks_reg;
    logic        m_valid_reg;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    i2cmra_seq u_seq (
        .state_cur       (state_reg),
        .cmd             (s_cmd),
        .device_control  (s_device_control),
        .reg_address     (s_reg_address),
        .write_data      (s_write_data),
        .sda_in          (s_sda_in),
        .ticks_per_phase (ticks_reg),
        .state_nxt       (state_next),
        .result          (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
        end else if (cfg_valid) begin
            ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_scl        = result_reg.scl;
    assign m_sda_out    = result_reg.sda_out;
    assign m_sda_drive  = result_reg.sda_drive;
    assign m_busy_res   = result_reg.busy;
    assign m_done_res   = result_reg.done;
    assign m_nack_error = result_reg.nack_error;
    assign m_read_data  = result_reg.read_data;

endmodule

/* hw/rtl/i2cmra_checker.sv */
// ----------------------------------------------------------------------------
// I2C master register access checker
// Port-level properties of the register access master, bound to the top
// level.
// ----------------------------------------------------------------------------
module i2cmra_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl,
    input logic       m_sda_out,
    input logic       m_sda_drive,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic       m_nack_error,
    input logic [7:0] m_read_data
);

    // A transaction that ends leaves the master idle in the same result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_done_res && m_busy_res))
        else $error("done and busy shown together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_nack_error) |-> m_done_res)
        else $error("NACK flag without done");

    // SDA is only released for an acknowledge or a read bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sda_drive) |-> m_busy_res)
        else $error("SDA released while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> (!m_scl && !m_sda_out && m_sda_drive))
        else $error("idle pin levels wrong");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data)))
        else $error("stalled result changed");

endmodule

bind i2c_master_register_access i2cmra_checker u_i2cmra_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_scl        (m_scl),
    .m_sda_out    (m_sda_out),
    .m_sda_drive  (m_sda_drive),
    .m_busy_res   (m_busy_res),
    .m_done_res   (m_done_res),
    .m_nack_error (m_nack_error),
    .m_read_data  (m_read_data)
);
